FILE: rtl/core/dwwn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types, constants and helper functions for the date / weekday / week number block.
// Depends on nothing; every module of the block imports it.

package dwwn_pkg;

	// Field widths of the date and result words.
	localparam int YearW  = 14;
	localparam int MonthW = 4;
	localparam int DayW   = 5;
	localparam int DoyW   = 9;

	// Day counts of whole Gregorian spans, reduced modulo 7 for the weekday.
	localparam int Days100Y     = 365 * 100 + 24;
	localparam int Days4Y       = 365 * 4 + 1;
	localparam int DaysYear     = 365;
	localparam int Days100Mod7  = Days100Y % 7;
	localparam int Days4Mod7    = Days4Y % 7;
	localparam int DaysYearMod7 = DaysYear % 7;

	// Reciprocal for year / 400 (exact for all 14-bit years).
	localparam int Recip400 = 41944;
	localparam int Shift400 = 24;

	// Reciprocal for t / 7 (exact for t below 512).
	localparam int Recip7 = 293;
	localparam int Shift7 = 11;

	// Month numbers used by the clamp and the leap-day correction.
	localparam logic [MonthW-1:0] MonthJan = 4'd1;
	localparam logic [MonthW-1:0] MonthFeb = 4'd2;
	localparam logic [MonthW-1:0] MonthDec = 4'd12;

	// Date word entering the block.
	typedef struct packed {
		logic [YearW-1:0]  year_value;
		logic [MonthW-1:0] month_value;
		logic [DayW-1:0]   day_value;
	} dwwn_date_t;

	// Result word leaving the block.
	typedef struct packed {
		logic [2:0]      weekday;
		logic [5:0]      week_number;
		logic [DoyW-1:0] day_of_year;
		logic            leap_year;
		logic            date_valid;
	} dwwn_result_t;

	// Word passed from the calendar half to the weekday half.
	typedef struct packed {
		logic [1:0]      cent;
		logic [4:0]      quad;
		logic [1:0]      yrs;
		logic [DoyW-1:0] elapsed;
		logic            leap;
		logic            valid;
	} dwwn_mid_t;

	// Residue modulo 7 of a 12-bit value. Since 8 is 1 modulo 7, the 3-bit digits
	// can be summed and folded once more before one final correction.
	function automatic logic [2:0] mod7(input logic [11:0] x);
		logic [4:0] s;
		logic [3:0] f;
		s = 5'(x[11:9]) + 5'(x[8:6]) + 5'(x[5:3]) + 5'(x[2:0]);
		f = 4'(s[4:3]) + 4'(s[2:0]);
		return (f >= 4'd7) ? 3'(f - 4'd7) : f[2:0];
	endfunction

	// Days in the months before the given month of a common year.
	function automatic logic [DoyW-1:0] cum_days(input logic [MonthW-1:0] m);
		logic [DoyW-1:0] v;
		unique case (m)
			4'd1:    v = 9'd0;
			4'd2:    v = 9'd31;
			4'd3:    v = 9'd59;
			4'd4:    v = 9'd90;
			4'd5:    v = 9'd120;
			4'd6:    v = 9'd151;
			4'd7:    v = 9'd181;
			4'd8:    v = 9'd212;
			4'd9:    v = 9'd243;
			4'd10:   v = 9'd273;
			4'd11:   v = 9'd304;
			4'd12:   v = 9'd334;
			default: v = 9'd0;
		endcase
		return v;
	endfunction

	// Length of the given month.
	function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m, input logic leap);
		logic [DayW-1:0] v;
		unique case (m)
			4'd2:                   v = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
			default:                v = 5'd31;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/core/date_weekday_week_number.sv
`timescale 1ns / 1ps
`default_nettype none
// Top level of the Gregorian weekday, week number and day-of-year block.
// Instantiates dwwn_calendar and dwwn_weekday; types from dwwn_pkg.
//
//  channel   handshake              word             content
//  request   req_valid / req_ready  req_data         year, month, day
//  response  rsp_valid / rsp_ready  rsp_data         weekday, week, day of year, flags
//
// A word passes through the four register stages, s1 and s2 in dwwn_calendar and s3 and s4
// in dwwn_weekday, the last being the response register; a new word can be accepted every
// cycle while the response side does not stall.
// Reset clears the stage valid bits only; there is no clearing pass.
// A stall on the response side holds each stage; a stage still loads when it is empty,
// so bubbles close up and nothing is dropped or repeated.

module date_weekday_week_number (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  dwwn_pkg::dwwn_date_t   req_data,
	output logic                   rsp_valid,
	input  logic                   rsp_ready,
	output dwwn_pkg::dwwn_result_t rsp_data
);
	import dwwn_pkg::*;

	logic      mid_valid;
	logic      mid_ready;
	dwwn_mid_t mid_data;

	// Year and date work.
	dwwn_calendar u_calendar (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_valid),
		.in_ready  (req_ready),
		.in_data   (req_data),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	// Weekday and week work.
	dwwn_weekday u_weekday (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mid_valid),
		.in_ready  (mid_ready),
		.in_data   (mid_data),
		.out_valid (rsp_valid),
		.out_ready (rsp_ready),
		.out_data  (rsp_data)
	);

endmodule

`default_nettype wire

FILE: rtl/core/dwwn_calendar.sv
`timescale 1ns / 1ps
`default_nettype none
// Calendar half: year reduction modulo 400, leap rule, day of year and date check.
// Two register stages; depends on dwwn_pkg.

module dwwn_calendar (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  dwwn_pkg::dwwn_date_t   in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output dwwn_pkg::dwwn_mid_t    out_data
);
	import dwwn_pkg::*;

	logic               en_s1, en_s2;
	logic               vld_s1, vld_s2;
	logic [YearW-1:0]   year_s1;
	logic [5:0]         q400_s1;
	logic [MonthW-1:0]  month_s1;
	logic [DayW-1:0]    day_s1;
	logic               bad_s1;
	dwwn_mid_t          mid_s2;

	logic [MonthW-1:0]  m_clamp;
	logic [DayW-1:0]    d_clamp;
	logic [31:0]        q400_prod;

	logic [8:0]         r400;
	logic               leap;
	logic [8:0]         r_since1;
	logic [1:0]         cent;
	logic [6:0]         rem100;
	logic [DoyW-1:0]    leap_add;
	logic [DayW-1:0]    mlen;
	dwwn_mid_t          mid_next;

	// Stage enables: a stage loads when it is empty or its word moves on.
	assign en_s2    = !vld_s2 || out_ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	// Stage 1 logic: clamp month and day, start year / 400 with a reciprocal multiply.
	always_comb begin
		if (in_data.month_value == '0) begin
			m_clamp = MonthJan;
		end else if (in_data.month_value > MonthDec) begin
			m_clamp = MonthDec;
		end else begin
			m_clamp = in_data.month_value;
		end
		d_clamp   = (in_data.day_value == '0) ? 5'd1 : in_data.day_value;
		q400_prod = 32'(in_data.year_value) * 32'(Recip400);
	end

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			year_s1  <= in_data.year_value;
			q400_s1  <= 6'(q400_prod >> Shift400);
			month_s1 <= m_clamp;
			day_s1   <= d_clamp;
			bad_s1   <= (in_data.month_value == '0) || (in_data.month_value > MonthDec) ||
			            (in_data.day_value == '0) || (in_data.year_value == '0);
		end
	end

	// Stage 2 logic: year modulo 400, leap flag, split of elapsed years, day of year.
	always_comb begin
		r400 = 9'(year_s1 - 14'(q400_s1) * 14'd400);
		leap = ((year_s1[1:0] == 2'b00) && (r400 != 9'd100) && (r400 != 9'd200) &&
		        (r400 != 9'd300)) || (r400 == 9'd0);
		// Years since year 1 within the 400-year span; year zero wraps to the end.
		r_since1 = (r400 == 9'd0) ? 9'd399 : (r400 - 9'd1);
		priority if (r_since1 >= 9'd300) begin
			cent = 2'd3;
		end else if (r_since1 >= 9'd200) begin
			cent = 2'd2;
		end else if (r_since1 >= 9'd100) begin
			cent = 2'd1;
		end else begin
			cent = 2'd0;
		end
		rem100   = 7'(r_since1 - 9'(cent) * 9'd100);
		leap_add = (leap && (month_s1 > MonthFeb)) ? 9'd1 : 9'd0;
		mlen     = month_len(month_s1, leap);

		mid_next.cent    = cent;
		mid_next.quad    = rem100[6:2];
		mid_next.yrs     = rem100[1:0];
		mid_next.elapsed = cum_days(month_s1) + leap_add + 9'(day_s1) - 9'd1;
		mid_next.leap    = leap;
		mid_next.valid   = !bad_s1 && (day_s1 <= mlen);
	end

	// Stage 2 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && vld_s1) begin
			mid_s2 <= mid_next;
		end
	end

	assign out_valid = vld_s2;
	assign out_data  = mid_s2;

endmodule

`default_nettype wire

FILE: rtl/core/dwwn_weekday.sv
`timescale 1ns / 1ps
`default_nettype none
// Weekday half: weekday of January 1, weekday of the date and week number.
// Two register stages, the second being the output register; depends on dwwn_pkg.

module dwwn_weekday (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  dwwn_pkg::dwwn_mid_t    in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output dwwn_pkg::dwwn_result_t out_data
);
	import dwwn_pkg::*;

	logic               en_s3, en_s4;
	logic               vld_s3, vld_s4;
	logic [8:0]         t_s3;
	logic [DoyW-1:0]    doy_s3;
	logic               leap_s3;
	logic               valid_s3;
	dwwn_result_t       res_s4;

	logic [11:0]        span_sum;
	logic [2:0]         jan1;
	logic [17:0]        wk_prod;
	dwwn_result_t       res_next;

	// Stage enables.
	assign en_s4    = !vld_s4 || out_ready;
	assign en_s3    = !vld_s3 || en_s4;
	assign in_ready = en_s3;

	// Stage 3 logic: January 1 weekday from the span counts, then days since that Monday base.
	always_comb begin
		span_sum = 12'(in_data.cent) * 12'(Days100Mod7) + 12'(in_data.quad) * 12'(Days4Mod7) +
		           12'(in_data.yrs) * 12'(DaysYearMod7);
		jan1     = mod7(span_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en_s3) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			t_s3     <= 9'(jan1) + in_data.elapsed;
			doy_s3   <= in_data.elapsed + 9'd1;
			leap_s3  <= in_data.leap;
			valid_s3 <= in_data.valid;
		end
	end

	// Stage 4 logic: week number by reciprocal of 7, weekday by residue.
	always_comb begin
		wk_prod              = 18'(t_s3) * 18'(Recip7);
		res_next.weekday     = mod7(12'(t_s3)) + 3'd1;
		res_next.week_number = 6'(wk_prod >> Shift7) + 6'd1;
		res_next.day_of_year = doy_s3;
		res_next.leap_year   = leap_s3;
		res_next.date_valid  = valid_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en_s4) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && vld_s3) begin
			res_s4 <= res_next;
		end
	end

	assign out_valid = vld_s4;
	assign out_data  = res_s4;

endmodule

`default_nettype wire

FILE: rtl/core/dwwn_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Port-level checks for the date / weekday / week number block, bound to the top level.
// Depends on dwwn_pkg.

module dwwn_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   req_valid,
	input logic                   req_ready,
	input dwwn_pkg::dwwn_date_t   req_data,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input dwwn_pkg::dwwn_result_t rsp_data
);
	import dwwn_pkg::*;

	// A waiting request word stays put until it is taken.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req_data))
		else $error("request word changed while waiting");

	// A stalled response word stays put.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("response word changed while stalled");

	// The weekday is always one of Monday through Sunday.
	a_weekday: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.weekday != 3'd0)
		else $error("weekday out of range");

	// Day of year and week number stay inside the year.
	a_ranges: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_data.day_of_year != 9'd0 && rsp_data.day_of_year <= 9'd366 &&
		              rsp_data.week_number != 6'd0 && rsp_data.week_number <= 6'd54)
		else $error("day of year or week number out of range");

	// A common year never reaches day 366.
	a_common_year: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.leap_year |-> rsp_data.day_of_year <= 9'd365)
		else $error("day 366 in a common year");

endmodule

bind date_weekday_week_number dwwn_checker u_dwwn_checker (.*);

`default_nettype wire

FILE: verif/date_weekday_week_number_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for date_weekday_week_number: dates in, weekday and week results out.
// Depends on dwwn_pkg for the date and result word types and the span day counts.

module date_weekday_week_number_tb;
	import dwwn_pkg::*;

	localparam int ResetCycles   = 6;
	localparam int RandomDates   = 1650;
	localparam int HoldStartItem = 400;
	localparam int HoldCycles    = 400;
	localparam int DrainCycles   = 12;
	localparam int CycleLimit    = 400000;
	localparam int DateW         = $bits(dwwn_date_t);

	// Expected calendar results, kept in acceptance order.
	class calendar_check;
		dwwn_result_t pending_results[$];
		int unsigned  mismatches = 0;

		static function bit is_leap(int unsigned y);
			return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
		endfunction

		static function int unsigned month_days(int unsigned y, int unsigned m);
			int unsigned lengths[12];
			lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
			if (m == 2 && is_leap(y)) begin
				return 29;
			end
			return lengths[m - 1];
		endfunction

		// Computes weekday, week, ordinal day and flags for one date.
		static function dwwn_result_t calendar_of(dwwn_date_t d);
			dwwn_result_t r;
			int unsigned  y, m, dd, offset, elapsed, span, days, jan1;
			bit           ok;
			y  = d.year_value;
			m  = d.month_value;
			dd = d.day_value;
			ok = 1'b1;
			// Out-of-range months and day zero are clamped but flagged.
			if (m == 0) begin
				m  = 1;
				ok = 1'b0;
			end
			if (m > 12) begin
				m  = 12;
				ok = 1'b0;
			end
			if (dd == 0) begin
				dd = 1;
				ok = 1'b0;
			end
			if (dd > month_days(y, m) || y == 0) begin
				ok = 1'b0;
			end
			offset = 0;
			for (int unsigned i = 1; i < m; i++) begin
				offset += month_days(y, i);
			end
			elapsed = offset + dd - 1;
			// Years since year 1 within one 400-year span; year 0 wraps to 399.
			span = (y + 399) % 400;
			days = Days100Y * (span / 100) + Days4Y * ((span % 100) / 4)
				+ DaysYear * (span % 4);
			jan1 = days % 7 + 1;
			r.weekday     = 3'((jan1 - 1 + elapsed) % 7 + 1);
			r.week_number = 6'((elapsed + jan1 - 1) / 7 + 1);
			r.day_of_year = 9'(elapsed + 1);
			r.leap_year   = is_leap(y);
			r.date_valid  = ok;
			return r;
		endfunction

		function void note_date(dwwn_date_t d);
			pending_results.push_back(calendar_of(d));
		endfunction

		function void check_result(dwwn_result_t r);
			dwwn_result_t want;
			if (pending_results.size() == 0) begin
				$error("unexpected result word %h", r);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			if (r.weekday != want.weekday) begin
				$error("weekday: expected %0d, actual %0d", want.weekday, r.weekday);
				mismatches++;
			end
			if (r.week_number != want.week_number) begin
				$error("week_number: expected %0d, actual %0d",
					want.week_number, r.week_number);
				mismatches++;
			end
			if (r.day_of_year != want.day_of_year) begin
				$error("day_of_year: expected %0d, actual %0d",
					want.day_of_year, r.day_of_year);
				mismatches++;
			end
			if (r.leap_year != want.leap_year) begin
				$error("leap_year: expected %0d, actual %0d", want.leap_year, r.leap_year);
				mismatches++;
			end
			if (r.date_valid != want.date_valid) begin
				$error("date_valid: expected %0d, actual %0d",
					want.date_valid, r.date_valid);
				mismatches++;
			end
		endfunction
	endclass

	logic         clk = 1'b0;
	logic         arst_n;
	logic         req_valid;
	logic         req_ready;
	dwwn_date_t   req_data;
	logic         rsp_valid;
	logic         rsp_ready;
	dwwn_result_t rsp_data;

	calendar_check calendar_sb = new;
	int unsigned   cycle_count = 0;
	int unsigned   burst_left  = 0;
	bit            hold_armed  = 1'b0;
	dwwn_date_t    directed_dates[$];

	date_weekday_week_number i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_data (rsp_data)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic dwwn_date_t make_date(int unsigned y, int unsigned m, int unsigned d);
		dwwn_date_t w;
		w.year_value  = YearW'(y);
		w.month_value = MonthW'(m);
		w.day_value   = DayW'(d);
		return w;
	endfunction

	// Mostly well-formed dates; the rest is raw noise or a day from the month's last day up to 31.
	function automatic dwwn_date_t random_date();
		int unsigned y, m, pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			return dwwn_date_t'(DateW'($urandom()));
		end
		y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 16383) : $urandom_range(1, 9999);
		m = $urandom_range(1, 12);
		if (pick < 15) begin
			return make_date(y, m, $urandom_range(calendar_check::month_days(y, m), 31));
		end
		if (pick < 22) begin
			// Year ends and starts, where the week number peaks.
			return make_date(y, (pick & 1) ? 12 : 1, (pick & 1) ? 31 : $urandom_range(1, 7));
		end
		return make_date(y, m, $urandom_range(1, calendar_check::month_days(y, m)));
	endfunction

	// Offers one date word and waits for its acceptance; gaps fall between bursts.
	task automatic offer_date(input dwwn_date_t d);
		int unsigned gap;
		req_data  <= d;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) begin
			@(posedge clk);
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Note accepted dates and check accepted results.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_ready) begin
				calendar_sb.note_date(req_data);
			end
			if (rsp_valid && rsp_ready) begin
				calendar_sb.check_result(rsp_data);
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Receiver: a changing stall pattern, plus one long hold-off so the pipeline backs up.
	initial begin
		int unsigned mode, phase_left, tick, period;
		bit          hold_done;
		rsp_ready <= 1'b0;
		hold_done = 1'b0;
		mode = 0;
		phase_left = 0;
		tick = 0;
		period = 2;
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_done) begin
				rsp_ready <= 1'b0;
				repeat (HoldCycles) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				if (phase_left == 0) begin
					mode = $urandom_range(0, 4);
					period = $urandom_range(2, 5);
					phase_left = $urandom_range(16, 96);
				end
				phase_left--;
				tick++;
				case (mode)
					0: rsp_ready <= 1'b1;
					1: rsp_ready <= $urandom_range(0, 1);
					2: rsp_ready <= $urandom_range(0, 7) != 0;
					3: rsp_ready <= (tick % period) != 0;
					default: rsp_ready <= $urandom_range(0, 3) == 0;
				endcase
			end
		end
	end

	// Reset, directed dates, random dates, drain and verdict.
	initial begin
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req_data  <= '0;
		repeat (ResetCycles) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_dates.push_back(make_date(1, 1, 1));        // epoch Monday
		directed_dates.push_back(make_date(0, 1, 1));        // year zero
		directed_dates.push_back(make_date(0, 0, 0));        // everything zero
		directed_dates.push_back(make_date(9999, 12, 31));
		directed_dates.push_back(make_date(16383, 15, 31));  // every bit set
		directed_dates.push_back(make_date(2000, 2, 29));    // leap by the 400 rule
		directed_dates.push_back(make_date(1900, 2, 29));    // century, not leap
		directed_dates.push_back(make_date(2024, 2, 29));
		directed_dates.push_back(make_date(2023, 2, 29));
		directed_dates.push_back(make_date(2012, 12, 31));   // week 54
		directed_dates.push_back(make_date(2000, 12, 31));   // day 366
		directed_dates.push_back(make_date(1999, 12, 31));
		directed_dates.push_back(make_date(2024, 0, 10));    // month zero
		directed_dates.push_back(make_date(2024, 13, 5));    // month past December
		directed_dates.push_back(make_date(2024, 3, 0));     // day zero
		directed_dates.push_back(make_date(2024, 4, 31));    // day past month end
		directed_dates.push_back(make_date(4, 2, 29));
		directed_dates.push_back(make_date(100, 2, 29));
		directed_dates.push_back(make_date(400, 2, 29));
		directed_dates.push_back(make_date(12000, 6, 15));   // above 9999
		directed_dates.push_back(make_date(10000, 2, 29));
		directed_dates.push_back(make_date(1600, 1, 1));
		directed_dates.push_back(make_date(8191, 7, 4));
		directed_dates.push_back(make_date(2025, 6, 30));
		foreach (directed_dates[i]) begin
			offer_date(directed_dates[i]);
		end

		for (int i = 0; i < RandomDates; i++) begin
			if (i == HoldStartItem) begin
				hold_armed = 1'b1;
			end
			offer_date(random_date());
		end
		req_valid <= 1'b0;

		while (calendar_sb.pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (calendar_sb.mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/dwwn_pkg.sv
rtl/core/dwwn_calendar.sv
rtl/core/dwwn_weekday.sv
rtl/core/date_weekday_week_number.sv
rtl/core/dwwn_checker.sv
verif/date_weekday_week_number_tb.sv
